@@ rtl/pla_pkg.sv @@
// Package for the positional array list: action codes, fixed field widths
// and the control bundle that the top level broadcasts to every entry cell.
// No dependencies.
package pla_pkg;

  localparam int unsigned ACTION_BITS = 2;
  localparam int unsigned POS_BITS    = 7;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned COUNT_BITS  = 7;

  localparam logic [ACTION_BITS-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_BITS-1:0] ACT_REMOVE = 2'd1;
  localparam logic [ACTION_BITS-1:0] ACT_SEARCH = 2'd2;

  // Per-cycle command seen by every cell of the chain.
  typedef struct packed {
    logic ins;   // accepted insert that succeeds
    logic rem;   // accepted remove that succeeds
    logic srch;  // accepted search
  } cell_ctl_t;

endpackage

@@ rtl/positional_array_list.sv @@
// Top level of the positional array list: a chain of entry cells plus the
// fill counter and result logic.
// Depends on pla_pkg and pla_cell.
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+------------------------------
//   command | in        | start && !busy     | action, position, value
//   result  | out       | done (one cycle)   | ok, count
//
// Every item is accepted at a clock edge and its result is shown with done
// high in the very next cycle. The cells shift or compare all entries at that
// edge, so an item may be accepted in every cycle and busy stays low.
// Search match flags are registered in each cell and OR-reduced in the
// result cycle. Reset (rst, synchronous) empties the list and clears done;
// entry words are not cleared, since entries at or above the count are never
// read. The receiver cannot stall, so no result is ever held back.
module positional_array_list
  import pla_pkg::*;
#(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [ACTION_BITS-1:0]       action,
  input  logic [POS_BITS-1:0]          position,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         done,
  output logic                         ok,
  output logic [COUNT_BITS-1:0]        count
);

  // Width of the fill counter, and a common width for comparing it with a
  // position.
  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (FW > POS_BITS) ? FW : POS_BITS;

  logic [FW-1:0]        fill;
  logic [CW-1:0]        fill_w;
  logic [CW-1:0]        pos_w;
  logic [WORD_BITS-1:0] key;
  logic                 accept;
  logic                 ins_ok;
  logic                 rem_ok;
  cell_ctl_t            ctl;
  logic                 was_search;
  logic                 op_ok;

  logic [WORD_BITS-1:0] ent   [CAPACITY];
  logic [CAPACITY-1:0]  match;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign fill_w = CW'(fill);
  assign pos_w  = CW'(position);

  // The stored word is the low WORD_BITS bits of the value, zero-extended
  // when the word is wider than the value field.
  generate
    if (WORD_BITS <= VALUE_BITS) begin : g_key_narrow
      assign key = value[WORD_BITS-1:0];
    end else begin : g_key_wide
      assign key = {{(WORD_BITS - VALUE_BITS){1'b0}}, value};
    end
  endgenerate

  // An insert needs a position no greater than the count and a free slot; a
  // remove needs a position below the count. A failing action leaves the
  // list alone.
  assign ins_ok = (action == ACT_INSERT) && (pos_w <= fill_w) &&
                  (fill_w < CW'(CAPACITY));
  assign rem_ok = (action == ACT_REMOVE) && (pos_w < fill_w);

  assign ctl.ins  = accept && ins_ok;
  assign ctl.rem  = accept && rem_ok;
  assign ctl.srch = accept && (action == ACT_SEARCH);

  // The chain: cell zero sees the new word on its left, the last cell sees
  // its own entry on its right.
  generate
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_w;
      logic [WORD_BITS-1:0] right_w;

      if (i == 0) begin : g_first
        assign left_w = key;
      end else begin : g_mid_l
        assign left_w = ent[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
        assign right_w = ent[i];
      end else begin : g_mid_r
        assign right_w = ent[i+1];
      end

      pla_cell #(
        .WORD_BITS (WORD_BITS),
        .CW        (CW),
        .INDEX     (i)
      ) u_cell (
        .clk   (clk),
        .ctl   (ctl),
        .pos   (pos_w),
        .fill  (fill_w),
        .key   (key),
        .left  (left_w),
        .right (right_w),
        .entry (ent[i]),
        .match (match[i])
      );
    end
  endgenerate

  // Fill counter and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill       <= '0;
      done       <= 1'b0;
      was_search <= 1'b0;
      op_ok      <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        was_search <= (action == ACT_SEARCH);
        op_ok      <= ins_ok || rem_ok;
        if (ins_ok) begin
          fill <= fill + FW'(1);
        end else if (rem_ok) begin
          fill <= fill - FW'(1);
        end
      end
    end
  end

  // A search succeeds if any held cell flagged a match.
  assign ok = done && (was_search ? (|match) : op_ok);

  // The count is reported in its fixed field width, masked or zero-extended.
  generate
    if (FW >= COUNT_BITS) begin : g_cnt_trunc
      assign count = fill[COUNT_BITS-1:0];
    end else begin : g_cnt_ext
      assign count = {{(COUNT_BITS - FW){1'b0}}, fill};
    end
  endgenerate

endmodule

@@ rtl/pla_cell.sv @@
// One entry cell of the positional array list chain.
// Depends on pla_pkg (cell_ctl_t).
module pla_cell
  import pla_pkg::*;
#(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned CW        = 7,
  parameter int unsigned INDEX     = 0
) (
  input  logic                 clk,
  input  cell_ctl_t            ctl,
  input  logic [CW-1:0]        pos,
  input  logic [CW-1:0]        fill,
  input  logic [WORD_BITS-1:0] key,
  input  logic [WORD_BITS-1:0] left,
  input  logic [WORD_BITS-1:0] right,
  output logic [WORD_BITS-1:0] entry,
  output logic                 match
);

  localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

  // Insert takes the left neighbor above the position and the new word at
  // it; remove takes the right neighbor from the position upward.
  always_ff @(posedge clk) begin
    if (ctl.ins && (MY_INDEX > pos)) begin
      entry <= left;
    end else if (ctl.ins && (MY_INDEX == pos)) begin
      entry <= key;
    end else if (ctl.rem && (MY_INDEX >= pos)) begin
      entry <= right;
    end
    match <= ctl.srch && (MY_INDEX < fill) && (entry == key);
  end

endmodule
